@@ hdl/srle_pkg.sv @@
// ----------------------------------------------------------------------------
// srle_pkg
// Shared types and constants for the sprite RLE stream decoder.
// ----------------------------------------------------------------------------
package srle_pkg;

    localparam int MAX_FRAMES_DEF = 256;

    localparam int WORD_W   = 16;
    localparam int RUN_W    = 15;
    localparam int OFF_W    = 32;
    localparam int FIDX_W   = 8;
    localparam int HWC_W    = 17;
    localparam int TDATA_W  = 128;
    localparam int TUSER_W  = 4;

    localparam logic [WORD_W-1:0] FMT_BIT_MASK  = 16'h0001;
    localparam logic [WORD_W-1:0] REQ_BIT_MASK  = 16'h0002;
    localparam logic [WORD_W-1:0] TAG_ODD_MASK  = 16'h0001;
    localparam logic [WORD_W-1:0] TAG_RUN_MASK  = 16'hFFFE;

    typedef enum logic [3:0] {
        PH_FLAGS_LO,
        PH_FLAGS_HI,
        PH_COUNT,
        PH_HEADER,
        PH_TAG,
        PH_PIXEL,
        PH_MARK,
        PH_DONE,
        PH_ERROR,
        PH_FSTART
    } t_phase;

    typedef enum logic [3:0] {
        KIND_HDR,
        KIND_FRAME_HDR,
        KIND_LITERAL,
        KIND_TRANSP,
        KIND_PIXEL,
        KIND_LINE_END,
        KIND_FRAME_END,
        KIND_FILE_END,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_FLAGS,
        ERR_FRAMES,
        ERR_MARKER,
        ERR_TRAILING
    } t_err;

    typedef struct packed {
        t_kind              kind;
        logic [FIDX_W-1:0]  frame_index;
        logic [WORD_W-1:0]  line_index;
        logic [OFF_W-1:0]   pixel_offset;
        logic [WORD_W-1:0]  pixel_value;
        logic [RUN_W-1:0]   run_length;
        logic [WORD_W-1:0]  frame_width;
        logic [WORD_W-1:0]  frame_height;
        logic               color_is_565;
        t_err               error_code;
    } t_result;

endpackage

@@ hdl/srle_height_mem.sv @@
// ----------------------------------------------------------------------------
// srle_height_mem
// Frame height table: one write port, one registered read port, write data
// forwarded on a same-address read.
// ----------------------------------------------------------------------------
module srle_height_mem #(
    parameter int MAX_FRAMES = srle_pkg::MAX_FRAMES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] i_wr_addr,
    input  logic [srle_pkg::WORD_W-1:0]     i_wr_data,
    input  logic                            i_rd_en,
    input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] i_rd_addr,
    output logic [srle_pkg::WORD_W-1:0]     o_rd_data
);

    logic [srle_pkg::WORD_W-1:0] r_mem [MAX_FRAMES];
    logic [srle_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/srle_parser.sv @@
// ----------------------------------------------------------------------------
// srle_parser
// File parser: phase tracking, header and run decoding, one result per beat.
// ----------------------------------------------------------------------------
module srle_parser #(
    parameter int MAX_FRAMES = srle_pkg::MAX_FRAMES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_acc,
    input  logic [srle_pkg::WORD_W-1:0]     i_word,
    input  logic                            i_start,
    input  logic [srle_pkg::WORD_W-1:0]     i_rd_data,
    output logic                            o_wr_en,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] o_wr_addr,
    output logic [srle_pkg::WORD_W-1:0]     o_wr_data,
    output logic                            o_rd_en,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] o_rd_addr,
    output srle_pkg::t_result               o_result
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int WW = srle_pkg::WORD_W;

    srle_pkg::t_phase           r_phase, n_phase, e_phase, ph_sel;
    logic                       r_req, n_req, e_req;
    logic                       r_fmt, n_fmt, e_fmt;
    logic [WW-1:0]              r_total, n_total, e_total;
    logic [CW-1:0]              r_fcnt, n_fcnt, e_fcnt;
    logic [srle_pkg::HWC_W-1:0] r_hwc, n_hwc, e_hwc;
    logic [WW-1:0]              r_hw, n_hw;
    logic [WW-1:0]              r_hh, n_hh;
    logic [WW-1:0]              r_cur_h, n_cur_h;
    logic [WW-1:0]              r_line, n_line, e_line;
    logic [srle_pkg::OFF_W-1:0] r_off, n_off, e_off;
    logic [srle_pkg::RUN_W-1:0] r_left, n_left, e_left;
    srle_pkg::t_err             r_err, n_err, e_err, err;

    logic [WW-1:0]              h_eff;
    logic [WW-1:0]              line_nx;
    logic [srle_pkg::RUN_W-1:0] run;
    logic [srle_pkg::RUN_W-1:0] left_nx;
    logic [srle_pkg::HWC_W:0]   last_k;
    logic [WW-1:0]              hdr_h;
    srle_pkg::t_kind            kind;
    logic [WW-1:0]              pv, fw, fh;
    logic [srle_pkg::RUN_W-1:0] run_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= srle_pkg::PH_FLAGS_LO;
            r_req   <= 1'b0;
            r_fmt   <= 1'b0;
            r_total <= '0;
            r_fcnt  <= '0;
            r_hwc   <= '0;
            r_line  <= '0;
            r_off   <= '0;
            r_left  <= '0;
            r_err   <= srle_pkg::ERR_NONE;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_req   <= n_req;
            r_fmt   <= n_fmt;
            r_total <= n_total;
            r_fcnt  <= n_fcnt;
            r_hwc   <= n_hwc;
            r_line  <= n_line;
            r_off   <= n_off;
            r_left  <= n_left;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_hw    <= n_hw;
            r_hh    <= n_hh;
            r_cur_h <= n_cur_h;
        end
    end

    always_comb begin
        e_phase = i_start ? srle_pkg::PH_FLAGS_LO : r_phase;
        e_req   = i_start ? 1'b0 : r_req;
        e_fmt   = i_start ? 1'b0 : r_fmt;
        e_total = i_start ? '0 : r_total;
        e_fcnt  = i_start ? '0 : r_fcnt;
        e_hwc   = i_start ? '0 : r_hwc;
        e_line  = i_start ? '0 : r_line;
        e_off   = i_start ? '0 : r_off;
        e_left  = i_start ? '0 : r_left;
        e_err   = i_start ? srle_pkg::ERR_NONE : r_err;

        if (e_phase == srle_pkg::PH_FSTART) begin
            ph_sel = (i_rd_data == '0) ? srle_pkg::PH_MARK : srle_pkg::PH_TAG;
            h_eff  = i_rd_data;
        end else begin
            ph_sel = e_phase;
            h_eff  = r_cur_h;
        end

        n_phase = e_phase;
        n_req   = e_req;
        n_fmt   = e_fmt;
        n_total = e_total;
        n_fcnt  = e_fcnt;
        n_hwc   = e_hwc;
        n_hw    = r_hw;
        n_hh    = r_hh;
        n_cur_h = h_eff;
        n_line  = e_line;
        n_off   = e_off;
        n_left  = e_left;
        n_err   = e_err;

        o_wr_en   = 1'b0;
        o_wr_addr = e_fcnt[AW-1:0];
        o_wr_data = i_word;
        o_rd_en   = 1'b0;

        err     = srle_pkg::ERR_NONE;
        kind    = srle_pkg::KIND_HDR;
        pv      = '0;
        fw      = '0;
        fh      = '0;
        run_o   = '0;

        run     = i_word[WW-1:1] & srle_pkg::TAG_RUN_MASK[WW-1:1];
        line_nx = e_line + 1'b1;
        left_nx = e_left - 1'b1;
        hdr_h   = (e_hwc == 17'd3) ? i_word : r_hh;
        last_k  = (hdr_h == '0) ? 18'd3
                : 18'd3 + {1'b0, (hdr_h - 1'b1), 1'b0};

        unique case (ph_sel)
            srle_pkg::PH_FLAGS_LO: begin
                n_req   = (i_word & srle_pkg::REQ_BIT_MASK) != '0;
                n_fmt   = (i_word & srle_pkg::FMT_BIT_MASK) != '0;
                n_phase = srle_pkg::PH_FLAGS_HI;
            end
            srle_pkg::PH_FLAGS_HI: begin
                if (!e_req) begin
                    err = srle_pkg::ERR_FLAGS;
                end else begin
                    n_phase = srle_pkg::PH_COUNT;
                end
            end
            srle_pkg::PH_COUNT: begin
                n_total = i_word;
                if ({1'b0, i_word} > 17'(MAX_FRAMES)) begin
                    err = srle_pkg::ERR_FRAMES;
                end else if (i_word == '0) begin
                    kind    = srle_pkg::KIND_FILE_END;
                    n_phase = srle_pkg::PH_DONE;
                end else begin
                    n_fcnt  = '0;
                    n_hwc   = '0;
                    n_phase = srle_pkg::PH_HEADER;
                end
            end
            srle_pkg::PH_HEADER: begin
                kind  = srle_pkg::KIND_FRAME_HDR;
                n_hwc = e_hwc + 1'b1;
                if (e_hwc == 17'd2) begin
                    n_hw = i_word;
                    fw   = i_word;
                end else if (e_hwc > 17'd2) begin
                    fw   = r_hw;
                end
                if (e_hwc == 17'd3) begin
                    n_hh    = i_word;
                    o_wr_en = i_acc;
                end
                if (e_hwc >= 17'd3) begin
                    fh = hdr_h;
                    if ({1'b0, e_hwc} >= last_k) begin
                        n_hwc  = '0;
                        n_fcnt = e_fcnt + 1'b1;
                        if (17'(n_fcnt) >= {1'b0, e_total}) begin
                            n_fcnt  = '0;
                            n_off   = '0;
                            n_line  = '0;
                            n_left  = '0;
                            n_phase = srle_pkg::PH_FSTART;
                            o_rd_en = i_acc;
                        end
                    end
                end
            end
            srle_pkg::PH_TAG: begin
                n_phase = srle_pkg::PH_TAG;
                if (i_word == '0) begin
                    kind   = srle_pkg::KIND_LINE_END;
                    n_line = line_nx;
                    if (line_nx >= h_eff) begin
                        n_phase = srle_pkg::PH_MARK;
                    end
                end else if ((i_word & srle_pkg::TAG_ODD_MASK) == '0) begin
                    kind  = srle_pkg::KIND_TRANSP;
                    run_o = run;
                    n_off = e_off + 32'(run);
                end else begin
                    kind   = srle_pkg::KIND_LITERAL;
                    run_o  = run;
                    n_left = run;
                    if (run != '0) begin
                        n_phase = srle_pkg::PH_PIXEL;
                    end
                end
            end
            srle_pkg::PH_PIXEL: begin
                kind   = srle_pkg::KIND_PIXEL;
                pv     = i_word;
                n_off  = e_off + 1'b1;
                n_left = left_nx;
                if (left_nx == '0) begin
                    n_phase = srle_pkg::PH_TAG;
                end
            end
            srle_pkg::PH_MARK: begin
                if (i_word != '0) begin
                    err = srle_pkg::ERR_MARKER;
                end else begin
                    n_fcnt = e_fcnt + 1'b1;
                    if (17'(n_fcnt) >= {1'b0, e_total}) begin
                        kind    = srle_pkg::KIND_FILE_END;
                        n_phase = srle_pkg::PH_DONE;
                    end else begin
                        kind    = srle_pkg::KIND_FRAME_END;
                        n_off   = '0;
                        n_line  = '0;
                        n_left  = '0;
                        n_phase = srle_pkg::PH_FSTART;
                        o_rd_en = i_acc;
                    end
                end
            end
            srle_pkg::PH_DONE: begin
                err = srle_pkg::ERR_TRAILING;
            end
            default: begin
                err = (e_err != srle_pkg::ERR_NONE) ? e_err : srle_pkg::ERR_TRAILING;
            end
        endcase

        if (err != srle_pkg::ERR_NONE) begin
            n_err   = err;
            n_phase = srle_pkg::PH_ERROR;
            kind    = srle_pkg::KIND_ERROR;
            pv      = '0;
            run_o   = '0;
            fw      = '0;
            fh      = '0;
        end

        o_rd_addr = n_fcnt[AW-1:0];

        o_result.kind         = kind;
        o_result.frame_index  = srle_pkg::FIDX_W'(e_fcnt);
        o_result.line_index   = e_line;
        o_result.pixel_offset = e_off;
        o_result.pixel_value  = pv;
        o_result.run_length   = run_o;
        o_result.frame_width  = fw;
        o_result.frame_height = fh;
        o_result.color_is_565 = n_fmt;
        o_result.error_code   = err;
    end

endmodule

@@ hdl/srle_out_buf.sv @@
// ----------------------------------------------------------------------------
// srle_out_buf
// Result output register with one skid stage.
// ----------------------------------------------------------------------------
module srle_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  srle_pkg::t_result   i_data,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_pop_ready,
    output srle_pkg::t_result   o_data
);

    logic              r_ov;
    logic              r_sv;
    srle_pkg::t_result r_out;
    srle_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_ov && i_pop_ready;
    assign o_ready = !r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (pop) begin
                r_sv <= 1'b0;
            end
        end else if (i_push) begin
            if (r_ov && !pop) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_ov && !pop) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule

@@ hdl/sprite_rle_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// sprite_rle_stream_decoder_unit
// Sprite file RLE decoder: one classified result beat per file word.
// ----------------------------------------------------------------------------
// channel  dir  width      contents
// s_axis   in   16 + 1     file word, tuser = file start
// m_axis   out  128 + 4    result fields, tuser = result kind
//
// One word per cycle sustained while the master side accepts; each word is
// decoded combinationally and its result lands in the output register. Frame
// heights live in a one-port-read memory read ahead of a frame's line data.
// Reset is synchronous; the table needs no clearing. A stalled master side is
// absorbed by a one-entry skid stage before the input is held off.
// ----------------------------------------------------------------------------
module sprite_rle_stream_decoder_unit #(
    parameter int MAX_FRAMES = srle_pkg::MAX_FRAMES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [srle_pkg::WORD_W-1:0]     i_s_tdata,  // stream_word
    input  logic                            i_s_tuser,  // file_start
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // frame_index, line_index, pixel_offset, pixel_value, run_length,
    // frame_width, frame_height, color_is_565, error_code, zero pad
    output logic [srle_pkg::TDATA_W-1:0]    o_m_tdata,
    output logic [srle_pkg::TUSER_W-1:0]    o_m_tuser   // result_kind
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic                        acc;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [srle_pkg::WORD_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [srle_pkg::WORD_W-1:0] rd_data;
    srle_pkg::t_result           res;
    srle_pkg::t_result           out_res;

    assign acc = i_s_tvalid && o_s_tready;

    srle_height_mem #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    srle_parser #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_word    (i_s_tdata),
        .i_start   (i_s_tuser),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_result  (res)
    );

    srle_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (acc),
        .i_data      (res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_data      (out_res)
    );

    assign o_m_tuser = out_res.kind;
    assign o_m_tdata = {5'd0,
                        out_res.error_code,
                        out_res.color_is_565,
                        out_res.frame_height,
                        out_res.frame_width,
                        out_res.run_length,
                        out_res.pixel_value,
                        out_res.pixel_offset,
                        out_res.line_index,
                        out_res.frame_index};

endmodule

@@ sim/sprite_rle_stream_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sprite_rle_stream_decoder_unit_tb
// Streams sprite files word by word into the decoder and checks every result
// beat against a cycle-free model of the file parser kept in this bench.
// Covers directed files (formats, run kinds, empty literal, zero height,
// last end marker, trailing data, flag/count/marker errors, restart),
// a 256-frame file, a long output hold-off and random well-formed,
// truncated and noisy files under several idle/stall mixes.
// ----------------------------------------------------------------------------
module sprite_rle_stream_decoder_unit_tb;

    localparam int FRAMES_MAX = srle_pkg::MAX_FRAMES_DEF;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [srle_pkg::WORD_W-1:0] word;
        logic                        start;
    } t_file_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [srle_pkg::WORD_W-1:0]   i_s_tdata;   // stream_word
    logic                          i_s_tuser;   // file_start
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    // frame_index, line_index, pixel_offset, pixel_value, run_length,
    // frame_width, frame_height, color_is_565, error_code, zero pad
    logic [srle_pkg::TDATA_W-1:0]  o_m_tdata;
    logic [srle_pkg::TUSER_W-1:0]  o_m_tuser;   // result_kind

    // parser model state
    srle_pkg::t_phase              ph;
    logic [srle_pkg::WORD_W-1:0]   flags_lo;
    logic                          fmt565;
    logic [srle_pkg::WORD_W-1:0]   frames_total;
    logic [8:0]                    frame_cnt;
    logic [srle_pkg::HWC_W-1:0]    hdr_words;
    logic [srle_pkg::WORD_W-1:0]   width_tab [FRAMES_MAX];
    logic [srle_pkg::WORD_W-1:0]   height_tab [FRAMES_MAX];
    logic [srle_pkg::WORD_W-1:0]   cur_line;
    logic [srle_pkg::OFF_W-1:0]    pix_off;
    logic [srle_pkg::RUN_W-1:0]    lit_left;
    srle_pkg::t_err                err_hold;

    srle_pkg::t_result             decoded_words [$];
    t_file_word                    file_words [$];

    int                   src_idle_pct = 0;
    int                   snk_stall_pct = 0;
    int                   hold_cycles = 0;
    int                   hold_count = 0;
    int                   words_sent = 0;
    int                   files_sent = 0;
    int                   results_seen = 0;
    int                   mismatches = 0;
    int                   cycles = 0;

    sprite_rle_stream_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic void restart_parse();
        ph = srle_pkg::PH_FLAGS_LO;
        flags_lo = '0;
        fmt565 = 1'b0;
        frames_total = '0;
        frame_cnt = '0;
        hdr_words = '0;
        cur_line = '0;
        pix_off = '0;
        lit_left = '0;
        err_hold = srle_pkg::ERR_NONE;
    endfunction

    function automatic void enter_frame_data();
        pix_off = '0;
        cur_line = '0;
        lit_left = '0;
        if (frame_cnt < FRAMES_MAX && height_tab[frame_cnt[7:0]] != 0) begin
            ph = srle_pkg::PH_TAG;
        end else begin
            ph = srle_pkg::PH_MARK;
        end
    endfunction

    function automatic srle_pkg::t_result decode_file_word(
        input logic [srle_pkg::WORD_W-1:0] w,
        input logic                        st
    );
        srle_pkg::t_result           r;
        srle_pkg::t_err              e;
        logic [srle_pkg::HWC_W-1:0]  k;
        logic [8:0]                  f;
        logic [srle_pkg::WORD_W-1:0] h;
        int                          hlen;
        if (st) restart_parse();
        r = '0;
        r.kind = srle_pkg::KIND_HDR;
        r.frame_index = frame_cnt[7:0];
        r.line_index = cur_line;
        r.pixel_offset = pix_off;
        e = srle_pkg::ERR_NONE;
        case (ph)
            srle_pkg::PH_FLAGS_LO: begin
                flags_lo = w;
                fmt565 = (w & srle_pkg::FMT_BIT_MASK) != 0;
                ph = srle_pkg::PH_FLAGS_HI;
            end
            srle_pkg::PH_FLAGS_HI: begin
                if ((flags_lo & srle_pkg::REQ_BIT_MASK) == 0) e = srle_pkg::ERR_FLAGS;
                else ph = srle_pkg::PH_COUNT;
            end
            srle_pkg::PH_COUNT: begin
                frames_total = w;
                if (w > FRAMES_MAX) begin
                    e = srle_pkg::ERR_FRAMES;
                end else if (w == 0) begin
                    r.kind = srle_pkg::KIND_FILE_END;
                    ph = srle_pkg::PH_DONE;
                end else begin
                    frame_cnt = '0;
                    hdr_words = '0;
                    ph = srle_pkg::PH_HEADER;
                end
            end
            srle_pkg::PH_HEADER: begin
                k = hdr_words;
                f = frame_cnt;
                r.kind = srle_pkg::KIND_FRAME_HDR;
                if (f >= FRAMES_MAX) begin
                    e = srle_pkg::ERR_FRAMES;
                end else begin
                    if (k == 2) width_tab[f[7:0]] = w;
                    if (k == 3) height_tab[f[7:0]] = w;
                    if (k >= 2) r.frame_width = width_tab[f[7:0]];
                    if (k >= 3) r.frame_height = height_tab[f[7:0]];
                    hdr_words = k + 1'b1;
                    if (k >= 3) begin
                        h = height_tab[f[7:0]];
                        hlen = (h == 0) ? 4 : 2 + 2 * int'(h);
                        if (int'(k) + 1 >= hlen) begin
                            hdr_words = '0;
                            frame_cnt = f + 1'b1;
                            if (frame_cnt >= frames_total) begin
                                frame_cnt = '0;
                                enter_frame_data();
                            end
                        end
                    end
                end
            end
            srle_pkg::PH_TAG: begin
                if (w == 0) begin
                    r.kind = srle_pkg::KIND_LINE_END;
                    cur_line = cur_line + 1'b1;
                    if (frame_cnt >= FRAMES_MAX ||
                        cur_line >= height_tab[frame_cnt[7:0]])
                        ph = srle_pkg::PH_MARK;
                end else if ((w & srle_pkg::TAG_ODD_MASK) == 0) begin
                    r.kind = srle_pkg::KIND_TRANSP;
                    r.run_length = srle_pkg::RUN_W'((w & srle_pkg::TAG_RUN_MASK) >> 1);
                    pix_off = pix_off + r.run_length;
                end else begin
                    r.kind = srle_pkg::KIND_LITERAL;
                    r.run_length = srle_pkg::RUN_W'((w & srle_pkg::TAG_RUN_MASK) >> 1);
                    lit_left = r.run_length;
                    if (r.run_length != 0) ph = srle_pkg::PH_PIXEL;
                end
            end
            srle_pkg::PH_PIXEL: begin
                r.kind = srle_pkg::KIND_PIXEL;
                r.pixel_value = w;
                pix_off = pix_off + 1'b1;
                lit_left = lit_left - 1'b1;
                if (lit_left == 0) ph = srle_pkg::PH_TAG;
            end
            srle_pkg::PH_MARK: begin
                if (w != 0) begin
                    e = srle_pkg::ERR_MARKER;
                end else begin
                    frame_cnt = frame_cnt + 1'b1;
                    if (frame_cnt >= frames_total) begin
                        r.kind = srle_pkg::KIND_FILE_END;
                        ph = srle_pkg::PH_DONE;
                    end else begin
                        r.kind = srle_pkg::KIND_FRAME_END;
                        enter_frame_data();
                    end
                end
            end
            srle_pkg::PH_DONE: e = srle_pkg::ERR_TRAILING;
            default: e = (err_hold != srle_pkg::ERR_NONE) ? err_hold
                                                           : srle_pkg::ERR_TRAILING;
        endcase
        if (e != srle_pkg::ERR_NONE) begin
            err_hold = e;
            ph = srle_pkg::PH_ERROR;
            r.kind = srle_pkg::KIND_ERROR;
            r.pixel_value = '0;
            r.run_length = '0;
            r.frame_width = '0;
            r.frame_height = '0;
        end
        r.color_is_565 = fmt565;
        r.error_code = e;
        return r;
    endfunction

    function automatic string result_text(input srle_pkg::t_result r);
        return $sformatf({"kind=%0d frame=%0d line=%0d off=%08h pix=%04h run=%0d ",
                          "w=%0d h=%0d 565=%0b err=%0d"},
                         r.kind, r.frame_index, r.line_index, r.pixel_offset,
                         r.pixel_value, r.run_length, r.frame_width, r.frame_height,
                         r.color_is_565, r.error_code);
    endfunction

    function automatic void put_word(input logic [srle_pkg::WORD_W-1:0] w, input logic st);
        t_file_word fw;
        fw.word = w;
        fw.start = st;
        file_words.push_back(fw);
    endfunction

    // mostly well-formed files with random content; some broken or truncated
    function automatic void make_random_file();
        int unsigned sel, frames, h, ntags, npix, run, base, cut;
        int unsigned heights [$];
        logic [srle_pkg::WORD_W-1:0] lo;
        base = file_words.size();
        lo = srle_pkg::WORD_W'($urandom);
        if ($urandom_range(99) < 92) lo = lo | srle_pkg::REQ_BIT_MASK;
        put_word(lo, 1'b1);
        put_word(srle_pkg::WORD_W'($urandom), 1'b0);
        sel = $urandom_range(99);
        if (sel < 4) frames = 0;
        else if (sel < 8) frames = $urandom_range(65535, FRAMES_MAX + 1);
        else if (sel < 15) frames = $urandom_range(12, 5);
        else frames = $urandom_range(4, 1);
        put_word(srle_pkg::WORD_W'(frames), 1'b0);
        if (frames != 0 && frames <= FRAMES_MAX) begin
            for (int f = 0; f < frames; f++) begin
                h = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
                heights.push_back(h);
                put_word(srle_pkg::WORD_W'($urandom), 1'b0);
                put_word(srle_pkg::WORD_W'($urandom), 1'b0);
                put_word(srle_pkg::WORD_W'($urandom), 1'b0);
                put_word(srle_pkg::WORD_W'(h), 1'b0);
                for (int i = 0; i < 2 * int'(h) - 2; i++)
                    put_word(srle_pkg::WORD_W'($urandom), 1'b0);
            end
            for (int f = 0; f < frames; f++) begin
                for (int l = 0; l < heights[f]; l++) begin
                    ntags = $urandom_range(5);
                    for (int t = 0; t < ntags; t++) begin
                        if ($urandom_range(1) == 0) begin
                            run = ($urandom_range(7) == 0) ? $urandom_range(32767, 1)
                                                           : $urandom_range(20, 1);
                            put_word(srle_pkg::WORD_W'(run << 1), 1'b0);
                        end else begin
                            npix = ($urandom_range(19) == 0) ? $urandom_range(40, 5)
                                                             : $urandom_range(4);
                            put_word(srle_pkg::WORD_W'((npix << 1) | 1), 1'b0);
                            for (int p = 0; p < npix; p++)
                                put_word(srle_pkg::WORD_W'($urandom), 1'b0);
                        end
                    end
                    put_word('0, 1'b0);
                end
                if ($urandom_range(49) == 0)
                    put_word(srle_pkg::WORD_W'($urandom_range(65535, 1)), 1'b0);
                else
                    put_word('0, 1'b0);
            end
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(2, 1)) put_word(srle_pkg::WORD_W'($urandom), 1'b0);
        end
        if ($urandom_range(99) < 8) begin
            cut = $urandom_range(file_words.size() - 1, base + 1);
            while (file_words.size() > cut) void'(file_words.pop_back());
        end
    endfunction

    task automatic send_file_word(input logic [srle_pkg::WORD_W-1:0] w, input logic st);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tdata <= w;
        i_s_tuser <= st;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        decoded_words.push_back(decode_file_word(w, st));
        words_sent++;
    endtask

    task automatic send_file_words();
        foreach (file_words[i]) send_file_word(file_words[i].word, file_words[i].start);
        file_words.delete();
        files_sent++;
    endtask

    task automatic settle_results();
        i_s_tvalid <= 1'b0;
        while (decoded_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_basic_file();
        logic [srle_pkg::WORD_W-1:0] words [] = '{
            16'h0003, 16'hFFFF, 16'd2,
            16'h1234, 16'h0000, 16'hFFFF, 16'd2, 16'hAAAA, 16'h5555,
            16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0004, 16'h0005, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000,
            16'hFFFE, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'hFFFF};
        src_idle_pct = 0;
        snk_stall_pct = 0;
        // first file relies on the reset state, no start flag
        foreach (words[i]) put_word(words[i], 1'b0);
        send_file_words();
        settle_results();
    endtask

    task automatic test_format_errors();
        logic [srle_pkg::WORD_W-1:0] words [] = '{
            16'h0001, 16'hABCD, 16'h5555,
            16'h0002, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
            16'hFFFF, 16'hFFFF, 16'd257, 16'h0001,
            16'h0003, 16'h0000, 16'hFFFF,
            16'h0003, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
            16'h1111, 16'h2222, 16'h3333,
            16'h0002, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0003, 16'h0001,
            16'h0000, 16'h8000, 16'h0000};
        logic starts [] = '{
            1, 0, 0,
            1, 0, 0, 0, 0,
            1, 0, 0, 0,
            1, 0, 0,
            1, 0, 0, 0, 0, 0, 0,
            0, 0, 0,
            1, 0, 0, 0, 0, 0, 0,
            0, 0, 0};
        src_idle_pct = 19;
        snk_stall_pct = 19;
        foreach (words[i]) put_word(words[i], starts[i]);
        send_file_words();
        settle_results();
    endtask

    task automatic test_frame_count_limit();
        src_idle_pct = 0;
        snk_stall_pct = 19;
        put_word(16'h0002, 1'b1);
        put_word(16'h0000, 1'b0);
        put_word(srle_pkg::WORD_W'(FRAMES_MAX), 1'b0);
        for (int f = 0; f < FRAMES_MAX; f++) begin
            put_word(srle_pkg::WORD_W'($urandom), 1'b0);
            put_word(srle_pkg::WORD_W'($urandom), 1'b0);
            put_word(srle_pkg::WORD_W'($urandom), 1'b0);
            put_word('0, 1'b0);
        end
        for (int f = 0; f < FRAMES_MAX; f++) put_word('0, 1'b0);
        send_file_words();
        settle_results();
    endtask

    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        while (file_words.size() < 120) make_random_file();
        hold_cycles = 250;
        send_file_words();
        settle_results();
    endtask

    task automatic test_random_files();
        int start_cnt;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
                default: begin src_idle_pct = 19; snk_stall_pct = 19; end
            endcase
            start_cnt = words_sent;
            while (words_sent - start_cnt < 60) begin
                if ($urandom_range(24) == 0) begin
                    repeat ($urandom_range(3, 1))
                        send_file_word(srle_pkg::WORD_W'($urandom), 1'($urandom_range(1)));
                end
                make_random_file();
                send_file_words();
            end
            settle_results();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_count < hold_cycles) begin
            hold_count++;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        srle_pkg::t_result got;
        srle_pkg::t_result want;
        bit                same;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind = srle_pkg::t_kind'(o_m_tuser);
            got.frame_index = o_m_tdata[7:0];
            got.line_index = o_m_tdata[23:8];
            got.pixel_offset = o_m_tdata[55:24];
            got.pixel_value = o_m_tdata[71:56];
            got.run_length = o_m_tdata[86:72];
            got.frame_width = o_m_tdata[102:87];
            got.frame_height = o_m_tdata[118:103];
            got.color_is_565 = o_m_tdata[119];
            got.error_code = srle_pkg::t_err'(o_m_tdata[122:120]);
            results_seen++;
            if (decoded_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %s", result_text(got));
            end else begin
                want = decoded_words.pop_front();
                same = (got.kind === want.kind) &&
                       (got.frame_index === want.frame_index) &&
                       (got.line_index === want.line_index) &&
                       (got.pixel_offset === want.pixel_offset) &&
                       (got.pixel_value === want.pixel_value) &&
                       (got.run_length === want.run_length) &&
                       (got.frame_width === want.frame_width) &&
                       (got.frame_height === want.frame_height) &&
                       (got.color_is_565 === want.color_is_565) &&
                       (got.error_code === want.error_code);
                if (!same) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("beat %0d expected: %s", results_seen, result_text(want));
                        $display("beat %0d actual:   %s", results_seen, result_text(got));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= 1'b0;
        restart_parse();
        foreach (width_tab[i]) begin
            width_tab[i] = '0;
            height_tab[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_file();
        test_format_errors();
        test_frame_count_limit();
        test_output_backpressure();
        test_random_files();

        repeat (16) @(posedge i_clk);
        mismatches += decoded_words.size();
        $display("Sent %0d files / %0d words, checked %0d beats, %0d mismatches.",
                 files_sent, words_sent, results_seen, mismatches);
        $display("Covered run kinds, header/count/marker errors, 256 frames, output hold-off.");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
